// File: rtl/sgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, constants and attribute update functions for the SGR
// attribute updater.
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int SGR_PARAM_BITS = 16;
    localparam int SGR_COMP_BITS  = 8;
    localparam int SGR_RGB_BITS   = 3 * SGR_COMP_BITS;
    localparam int SGR_ACTS       = 3;   // decodes carried by one queue entry
    localparam int SGR_QDEPTH     = 2;

    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_RGB     = 2'd2;

    localparam int FLAG_ITALIC   = 0;
    localparam int FLAG_INVERSE  = 1;
    localparam int FLAG_HIDDEN   = 2;
    localparam int FLAG_STRIKE   = 3;
    localparam int FLAG_OVERLINE = 4;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_FORE = 2'd1,
        TGT_BACK = 2'd2,
        TGT_UL   = 2'd3
    } tgt_t;

    typedef enum logic [3:0] {
        ACT_NOP       = 4'd0,
        ACT_CLEAR     = 4'd1,
        ACT_WEIGHT    = 4'd2,
        ACT_ITALIC    = 4'd3,
        ACT_UNDERLINE = 4'd4,
        ACT_BLINK     = 4'd5,
        ACT_INVERSE   = 4'd6,
        ACT_HIDDEN    = 4'd7,
        ACT_STRIKE    = 4'd8,
        ACT_OVERLINE  = 4'd9,
        ACT_FORE      = 4'd10,
        ACT_BACK      = 4'd11,
        ACT_UL_CLEAR  = 4'd12
    } act_op_t;

    // arg: small value for the op; for ACT_FORE/ACT_BACK bit 4 selects
    // palette, bits 3:0 the index, zero means default color
    typedef struct packed {
        act_op_t    op;
        logic [4:0] arg;
    } act_t;

    typedef struct packed {
        act_t [SGR_ACTS-1:0]       acts;
        tgt_t                      rgb_target;
        logic [SGR_RGB_BITS-1:0]   rgb;
        logic                      pending;
        logic                      last;
    } sgr_entry_t;

    typedef struct packed {
        logic [1:0]              weight;
        logic [2:0]              underline;
        logic [1:0]              blink;
        logic [4:0]              flags;
        logic [1:0]              fore_kind;
        logic [SGR_RGB_BITS-1:0] fore_value;
        logic [1:0]              back_kind;
        logic [SGR_RGB_BITS-1:0] back_value;
        logic                    ulcolor_set;
        logic [SGR_RGB_BITS-1:0] ulcolor_rgb;
    } attr_t;

    typedef struct packed {
        logic [SGR_PARAM_BITS-1:0] param_value;
        logic                      seq_last;
    } sgr_in_t;

    typedef struct packed {
        logic [1:0]              out_weight;
        logic [2:0]              out_underline;
        logic [1:0]              out_blink;
        logic [4:0]              out_flags;
        logic [1:0]              out_fore_kind;
        logic [SGR_RGB_BITS-1:0] out_fore_value;
        logic [1:0]              out_back_kind;
        logic [SGR_RGB_BITS-1:0] out_back_value;
        logic                    out_ulcolor_set;
        logic [SGR_RGB_BITS-1:0] out_ulcolor_rgb;
        logic                    out_pending;
        logic                    out_last;
    } sgr_out_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } sgr_hs_t;

    function automatic attr_t apply_act(attr_t a, act_t x);
        attr_t r;
        r = a;
        case (x.op)
            ACT_NOP:       r = a;
            ACT_CLEAR:     r = '0;
            ACT_WEIGHT:    r.weight = x.arg[1:0];
            ACT_ITALIC:    r.flags[FLAG_ITALIC] = x.arg[0];
            ACT_UNDERLINE: r.underline = x.arg[2:0];
            ACT_BLINK:     r.blink = x.arg[1:0];
            ACT_INVERSE:   r.flags[FLAG_INVERSE] = x.arg[0];
            ACT_HIDDEN:    r.flags[FLAG_HIDDEN] = x.arg[0];
            ACT_STRIKE:    r.flags[FLAG_STRIKE] = x.arg[0];
            ACT_OVERLINE:  r.flags[FLAG_OVERLINE] = x.arg[0];
            ACT_FORE: begin
                r.fore_kind  = x.arg[4] ? KIND_PALETTE : KIND_DEFAULT;
                r.fore_value = SGR_RGB_BITS'(x.arg[3:0]);
            end
            ACT_BACK: begin
                r.back_kind  = x.arg[4] ? KIND_PALETTE : KIND_DEFAULT;
                r.back_value = SGR_RGB_BITS'(x.arg[3:0]);
            end
            ACT_UL_CLEAR: begin
                r.ulcolor_set = 1'b0;
                r.ulcolor_rgb = '0;
            end
            default:       r = a;
        endcase
        return r;
    endfunction

    function automatic attr_t apply_rgb(attr_t a, tgt_t t, logic [SGR_RGB_BITS-1:0] rgb);
        attr_t r;
        r = a;
        case (t)
            TGT_FORE: begin
                r.fore_kind  = KIND_RGB;
                r.fore_value = rgb;
            end
            TGT_BACK: begin
                r.back_kind  = KIND_RGB;
                r.back_value = rgb;
            end
            TGT_UL: begin
                r.ulcolor_set = 1'b1;
                r.ulcolor_rgb = rgb;
            end
            default:  r = a;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sgr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_front
// Accepts parameters, tracks truecolor sub-sequence collection and turns
// each request into a queue entry of decoded attribute actions.
// ----------------------------------------------------------------------------
module sgr_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sgr_pkg::sgr_in_t    s_data,
    output sgr_pkg::sgr_hs_t         push_hs,
    input  wire logic                push_ready,
    output sgr_pkg::sgr_entry_t      push_data
);
    import sgr_pkg::*;

    localparam int W = SGR_PARAM_BITS;

    localparam logic [W-1:0] CODE_RESET     = W'(0);
    localparam logic [W-1:0] CODE_BOLD      = W'(1);
    localparam logic [W-1:0] CODE_DIM       = W'(2);
    localparam logic [W-1:0] CODE_ITALIC    = W'(3);
    localparam logic [W-1:0] CODE_UL        = W'(4);
    localparam logic [W-1:0] CODE_BLINK     = W'(5);
    localparam logic [W-1:0] CODE_RAPID     = W'(6);
    localparam logic [W-1:0] CODE_INVERSE   = W'(7);
    localparam logic [W-1:0] CODE_HIDDEN    = W'(8);
    localparam logic [W-1:0] CODE_STRIKE    = W'(9);
    localparam logic [W-1:0] CODE_DBL_UL    = W'(21);
    localparam logic [W-1:0] CODE_NO_WEIGHT = W'(22);
    localparam logic [W-1:0] CODE_NO_ITALIC = W'(23);
    localparam logic [W-1:0] CODE_NO_UL     = W'(24);
    localparam logic [W-1:0] CODE_NO_BLINK  = W'(25);
    localparam logic [W-1:0] CODE_NO_INV    = W'(27);
    localparam logic [W-1:0] CODE_NO_HIDDEN = W'(28);
    localparam logic [W-1:0] CODE_NO_STRIKE = W'(29);
    localparam logic [W-1:0] CODE_FG_EXT    = W'(38);
    localparam logic [W-1:0] CODE_FG_DEF    = W'(39);
    localparam logic [W-1:0] CODE_BG_EXT    = W'(48);
    localparam logic [W-1:0] CODE_BG_DEF    = W'(49);
    localparam logic [W-1:0] CODE_OVERLINE  = W'(53);
    localparam logic [W-1:0] CODE_NO_OVER   = W'(55);
    localparam logic [W-1:0] CODE_UL_EXT    = W'(58);
    localparam logic [W-1:0] CODE_UL_DEF    = W'(59);
    localparam logic [W-1:0] SUB_RGB        = W'(2);
    localparam logic [W-1:0] FG_LO          = W'(30);
    localparam logic [W-1:0] FG_HI_LO       = W'(90);
    localparam logic [W-1:0] BG_LO          = W'(40);
    localparam logic [W-1:0] BG_HI_LO       = W'(100);
    localparam logic [W-1:0] COMP_MAX       = W'(255);

    function automatic act_t classify(logic [W-1:0] v);
        act_t a;
        logic [W-1:0] d;
        a.op  = ACT_NOP;
        a.arg = '0;
        d     = '0;
        if (v inside {[30:37]}) begin
            d = v - FG_LO;
            a = '{op: ACT_FORE, arg: {1'b1, d[3:0]}};
        end else if (v inside {[90:97]}) begin
            d = v - FG_HI_LO;
            a = '{op: ACT_FORE, arg: {2'b11, d[2:0]}};
        end else if (v inside {[40:47]}) begin
            d = v - BG_LO;
            a = '{op: ACT_BACK, arg: {1'b1, d[3:0]}};
        end else if (v inside {[100:107]}) begin
            d = v - BG_HI_LO;
            a = '{op: ACT_BACK, arg: {2'b11, d[2:0]}};
        end else begin
            case (v)
                CODE_RESET:     a = '{op: ACT_CLEAR,     arg: 5'd0};
                CODE_BOLD:      a = '{op: ACT_WEIGHT,    arg: 5'd1};
                CODE_DIM:       a = '{op: ACT_WEIGHT,    arg: 5'd2};
                CODE_ITALIC:    a = '{op: ACT_ITALIC,    arg: 5'd1};
                CODE_UL:        a = '{op: ACT_UNDERLINE, arg: 5'd1};
                CODE_BLINK:     a = '{op: ACT_BLINK,     arg: 5'd1};
                CODE_RAPID:     a = '{op: ACT_BLINK,     arg: 5'd2};
                CODE_INVERSE:   a = '{op: ACT_INVERSE,   arg: 5'd1};
                CODE_HIDDEN:    a = '{op: ACT_HIDDEN,    arg: 5'd1};
                CODE_STRIKE:    a = '{op: ACT_STRIKE,    arg: 5'd1};
                CODE_DBL_UL:    a = '{op: ACT_UNDERLINE, arg: 5'd2};
                CODE_NO_WEIGHT: a = '{op: ACT_WEIGHT,    arg: 5'd0};
                CODE_NO_ITALIC: a = '{op: ACT_ITALIC,    arg: 5'd0};
                CODE_NO_UL:     a = '{op: ACT_UNDERLINE, arg: 5'd0};
                CODE_NO_BLINK:  a = '{op: ACT_BLINK,     arg: 5'd0};
                CODE_NO_INV:    a = '{op: ACT_INVERSE,   arg: 5'd0};
                CODE_NO_HIDDEN: a = '{op: ACT_HIDDEN,    arg: 5'd0};
                CODE_NO_STRIKE: a = '{op: ACT_STRIKE,    arg: 5'd0};
                CODE_FG_DEF:    a = '{op: ACT_FORE,      arg: 5'd0};
                CODE_BG_DEF:    a = '{op: ACT_BACK,      arg: 5'd0};
                CODE_OVERLINE:  a = '{op: ACT_OVERLINE,  arg: 5'd1};
                CODE_NO_OVER:   a = '{op: ACT_OVERLINE,  arg: 5'd0};
                CODE_UL_DEF:    a = '{op: ACT_UL_CLEAR,  arg: 5'd0};
                default:        a = '{op: ACT_NOP,       arg: 5'd0};
            endcase
        end
        return a;
    endfunction

    function automatic tgt_t start_target(logic [W-1:0] v);
        tgt_t t;
        case (v)
            CODE_FG_EXT: t = TGT_FORE;
            CODE_BG_EXT: t = TGT_BACK;
            CODE_UL_EXT: t = TGT_UL;
            default:     t = TGT_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [SGR_COMP_BITS-1:0] clamp_comp(logic [W-1:0] v);
        logic [W-1:0] c;
        c = (v > COMP_MAX) ? COMP_MAX : v;
        return c[SGR_COMP_BITS-1:0];
    endfunction

    tgt_t             tgt_reg, tgt_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [W-1:0]     pv_reg [3];
    logic             pv_wr;
    logic             accept;
    logic [W-1:0]     v;
    logic             last;
    tgt_t             start;
    sgr_entry_t       entry;

    assign v       = s_data.param_value;
    assign last    = s_data.seq_last;
    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;
    assign start   = start_target(v);

    assign push_hs.valid = s_valid;
    assign push_hs.ready = push_ready;
    assign push_data     = entry;

    always_comb begin
        entry            = '0;
        entry.rgb_target = TGT_NONE;
        entry.last       = last;
        tgt_next         = tgt_reg;
        cnt_next         = cnt_reg;
        pv_wr            = 1'b0;
        if (tgt_reg == TGT_NONE) begin
            entry.acts[0] = classify(v);
            if (!last && start != TGT_NONE) begin
                tgt_next = start;
                cnt_next = 2'd0;
            end
        end else if (cnt_reg == 2'd3) begin
            // r, g collected; this request is b
            entry.rgb_target = tgt_reg;
            entry.rgb = {clamp_comp(pv_reg[1]), clamp_comp(pv_reg[2]), clamp_comp(v)};
            tgt_next = TGT_NONE;
            cnt_next = 2'd0;
        end else if (cnt_reg == 2'd0 && v != SUB_RGB) begin
            // extended color code not followed by the rgb selector
            entry.acts[0] = classify(v);
            tgt_next      = TGT_NONE;
            if (!last && start != TGT_NONE) begin
                tgt_next = start;
            end
        end else if (!last) begin
            pv_wr    = 1'b1;
            cnt_next = cnt_reg + 2'd1;
        end else begin
            // sequence ended early: replay buffered values as plain codes
            entry.acts[0] = (cnt_reg >= 2'd1) ? classify(pv_reg[0]) : '0;
            entry.acts[1] = (cnt_reg >= 2'd2) ? classify(pv_reg[1]) : '0;
            entry.acts[2] = classify(v);
            tgt_next      = TGT_NONE;
            cnt_next      = 2'd0;
        end
        entry.pending = (tgt_next != TGT_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg <= TGT_NONE;
            cnt_reg <= 2'd0;
        end else if (accept) begin
            tgt_reg <= tgt_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pv_wr) begin
            pv_reg[cnt_reg] <= v;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sgr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_queue
// Two-entry queue between the classifying front and the attribute back end.
// ----------------------------------------------------------------------------
module sgr_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sgr_pkg::sgr_hs_t     push_hs,
    output logic                      push_ready,
    input  wire sgr_pkg::sgr_entry_t  push_data,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output sgr_pkg::sgr_entry_t       pop_data
);
    import sgr_pkg::*;

    localparam int PW = $clog2(SGR_QDEPTH);

    sgr_entry_t     mem [SGR_QDEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    cnt_reg, cnt_next;
    logic           push, pop;

    assign push_ready = (cnt_reg != (PW+1)'(SGR_QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_hs.valid && push_hs.ready && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sgr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_back
// Applies queued actions to the attribute registers, which also serve as
// the output register of the result channel.
// ----------------------------------------------------------------------------
module sgr_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire sgr_pkg::sgr_entry_t  pop_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sgr_pkg::sgr_out_t         m_data
);
    import sgr_pkg::*;

    attr_t  attr_reg, attr_next;
    logic   pending_reg, last_reg;
    logic   m_valid_reg, m_valid_next;
    logic   pop;

    assign pop_ready = !m_valid_reg || m_ready;
    assign pop       = pop_valid && pop_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        attr_next = attr_reg;
        // actions are applied in arrival order
        for (int i = 0; i < SGR_ACTS; i++) begin
            attr_next = apply_act(attr_next, pop_data.acts[i]);
        end
        attr_next = apply_rgb(attr_next, pop_data.rgb_target, pop_data.rgb);
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg    <= '0;
            pending_reg <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                attr_reg    <= attr_next;
                pending_reg <= pop_data.pending;
                last_reg    <= pop_data.last;
            end
        end
    end

    always_comb begin
        m_data.out_weight      = attr_reg.weight;
        m_data.out_underline   = attr_reg.underline;
        m_data.out_blink       = attr_reg.blink;
        m_data.out_flags       = attr_reg.flags;
        m_data.out_fore_kind   = attr_reg.fore_kind;
        m_data.out_fore_value  = attr_reg.fore_value;
        m_data.out_back_kind   = attr_reg.back_kind;
        m_data.out_back_value  = attr_reg.back_value;
        m_data.out_ulcolor_set = attr_reg.ulcolor_set;
        m_data.out_ulcolor_rgb = attr_reg.ulcolor_rgb;
        m_data.out_pending     = pending_reg;
        m_data.out_last        = last_reg;
    end

endmodule
`default_nettype wire

// File: rtl/sgr_attribute_updater_unit.sv
`default_nettype none
// Flow: an accepted parameter request is written into the queue and then
// applied to the attribute registers. Throughput: one request per cycle
// while the queue has room; the front decodes in the accept cycle, the
// back end applies up to three decoded codes plus a color write per cycle.
// A two-entry queue decouples the front from output back-pressure.
// Reset (aresetn low, synchronous) clears all attributes, any truecolor
// collection in progress and the queue.
// ----------------------------------------------------------------------------
// sgr_attribute_updater_unit
// SGR parameter decoder keeping the current text rendition attributes.
// ----------------------------------------------------------------------------
module sgr_attribute_updater_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sgr_pkg::sgr_in_t   s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sgr_pkg::sgr_out_t       m_data
);
    import sgr_pkg::*;

    sgr_hs_t     push_hs;
    logic        push_ready;
    sgr_entry_t  push_data;
    logic        pop_valid;
    logic        pop_ready;
    sgr_entry_t  pop_data;

    sgr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_hs    (push_hs),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sgr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_hs    (push_hs),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sgr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire
